// File: sv/nlc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and classifier for the numeric literal checker.
// No dependencies.
package nlc_pkg;

  // character classes produced by the front end
  localparam logic [2:0] CL_SPACE = 3'd0;
  localparam logic [2:0] CL_DIGIT = 3'd1;
  localparam logic [2:0] CL_SIGN  = 3'd2;
  localparam logic [2:0] CL_POINT = 3'd3;
  localparam logic [2:0] CL_EXP   = 3'd4;
  localparam logic [2:0] CL_OTHER = 3'd5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // recognizer phases
  localparam logic [3:0] PH_LEAD     = 4'd0;
  localparam logic [3:0] PH_SIGN     = 4'd1;
  localparam logic [3:0] PH_INT      = 4'd2;
  localparam logic [3:0] PH_PT_NOINT = 4'd3;
  localparam logic [3:0] PH_PT_INT   = 4'd4;
  localparam logic [3:0] PH_FRAC     = 4'd5;
  localparam logic [3:0] PH_EXP      = 4'd6;
  localparam logic [3:0] PH_EXP_SIGN = 4'd7;
  localparam logic [3:0] PH_EXP_DIG  = 4'd8;
  localparam logic [3:0] PH_TRAIL    = 4'd9;
  localparam logic [3:0] PH_REJECT   = 4'd10;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [2:0] cls;
    logic       present;
    logic       last;
  } item_t;

  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] r;
    if (c inside {CH_SPACE, [CH_TAB:CH_CR]})    r = CL_SPACE;
    else if (c inside {[CH_ZERO:CH_NINE]})      r = CL_DIGIT;
    else if (c inside {CH_PLUS, CH_MINUS})      r = CL_SIGN;
    else if (c == CH_POINT)                     r = CL_POINT;
    else if (c inside {CH_LOW_E, CH_UP_E})      r = CL_EXP;
    else                                        r = CL_OTHER;
    return r;
  endfunction

endpackage

// File: sv/nlc_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words and classifies each byte.
// Depends on nlc_pkg.
module nlc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] text_byte
  input  logic          s_tuser,   // [0] byte_present
  input  logic          s_tlast,
  output logic          push,
  output nlc_pkg::item_t push_item,
  input  logic          q_full
);
  import nlc_pkg::*;

  logic seen_rst;

  // hold off the input during reset and until seen_rst is set after it
  always_ff @(posedge clk) begin
    if (rst) seen_rst <= 1'b0;
    else     seen_rst <= 1'b1;
  end

  assign s_tready          = seen_rst && !q_full;
  assign push              = s_tvalid && s_tready;
  assign push_item.cls     = classify(s_tdata);
  assign push_item.present = s_tuser;
  assign push_item.last    = s_tlast;

endmodule

// File: sv/nlc_queue.sv
`timescale 1ns / 1ps
// Short queue of classified words between front and back.
// Depends on nlc_pkg.
module nlc_queue #(
  parameter int DEPTH = nlc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  nlc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output nlc_pkg::item_t q_item
);
  import nlc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: sv/nlc_back.sv
`timescale 1ns / 1ps
// Back end: recognizer state and the verdict output register.
// Depends on nlc_pkg.
module nlc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  nlc_pkg::item_t q_item,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata   // [0] is_numeric, [7:1] zero
);
  import nlc_pkg::*;

  logic [3:0] phase;
  logic [3:0] stepped;
  logic [3:0] phase_next;
  logic       can_emit;
  logic       verdict;

  function automatic logic accepting(input logic [3:0] ph);
    return ph inside {PH_INT, PH_PT_INT, PH_FRAC, PH_EXP_DIG, PH_TRAIL};
  endfunction

  function automatic logic [3:0] advance(input logic [3:0] ph, input logic [2:0] cls);
    logic [3:0] r;
    r = PH_REJECT;
    if (ph < PH_REJECT) begin
      case (cls)
        CL_SPACE: begin
          if (ph == PH_LEAD)      r = PH_LEAD;
          else if (accepting(ph)) r = PH_TRAIL;
        end
        CL_DIGIT: begin
          if (ph inside {PH_LEAD, PH_SIGN, PH_INT})            r = PH_INT;
          else if (ph inside {PH_PT_NOINT, PH_PT_INT, PH_FRAC}) r = PH_FRAC;
          else if (ph inside {PH_EXP, PH_EXP_SIGN, PH_EXP_DIG}) r = PH_EXP_DIG;
        end
        CL_SIGN: begin
          if (ph == PH_LEAD)     r = PH_SIGN;
          else if (ph == PH_EXP) r = PH_EXP_SIGN;
        end
        CL_POINT: begin
          if (ph inside {PH_LEAD, PH_SIGN}) r = PH_PT_NOINT;
          else if (ph == PH_INT)            r = PH_PT_INT;
        end
        CL_EXP: begin
          if (ph inside {PH_INT, PH_PT_INT, PH_FRAC}) r = PH_EXP;
        end
        default: r = PH_REJECT;
      endcase
    end
    return r;
  endfunction

  assign can_emit = !m_tvalid || m_tready;
  // a last word needs a free output slot, other words never wait
  assign pop      = q_valid && (!q_item.last || can_emit);
  assign stepped  = q_item.present ? advance(phase, q_item.cls) : phase;
  assign verdict  = accepting(stepped);

  always_comb begin
    phase_next = phase;
    if (pop) phase_next = q_item.last ? PH_LEAD : stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (pop && q_item.last) m_tvalid <= 1'b1;
      else if (m_tready)      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) m_tdata <= {7'b0, verdict};
  end

endmodule

// File: sv/numeric_literal_checker.sv
`timescale 1ns / 1ps
// Top level of the numeric literal checker: front classifier, queue, back recognizer.
// Depends on nlc_pkg, nlc_front, nlc_queue, nlc_back.
//
//  channel  dir  tdata               tuser            tlast
//  s_*      in   [7:0] text_byte     [0] byte_present end_of_text
//  m_*      out  [0] is_numeric      -                -
//
// One input word per cycle while the queue has room; each word is queued, stepped by the
// recognizer at the queue head, and a last word's verdict is registered onto m_*.
// The queue of QUEUE_DEPTH words lets input continue while a verdict waits on m_tready;
// only last words wait for the output register.
// Synchronous reset clears queue, phase and m_tvalid; s_tready is low during reset.
module numeric_literal_checker #(
  parameter int QUEUE_DEPTH = nlc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tuser,   // [0] byte_present
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] is_numeric, [7:1] zero
);
  import nlc_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  nlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  nlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  nlc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for numeric_literal_checker: drives texts as byte words and checks
// each verdict against a phase tracker kept in the bench. Depends on nlc_pkg and the RTL.
module tb_top;
  import nlc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       last;
  } text_word_t;

  typedef enum int {MUT_REPLACE, MUT_INNER_SPACE, MUT_TAIL_JUNK, MUT_DROP, MUT_INSERT}
    mutation_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  text_word_t text_words[$];
  logic       expected_verdicts[$];
  logic [7:0] text_buf[$];
  logic [3:0] recognizer_phase = PH_LEAD;
  text_word_t next_word;
  logic       want_verdict;

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int error_count   = 0;
  int words_sent    = 0;
  int texts_checked = 0;
  int numeric_seen  = 0;
  int phase_words   = 0;

  numeric_literal_checker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic phase_accepts(logic [3:0] ph);
    return ph == PH_INT || ph == PH_PT_INT || ph == PH_FRAC || ph == PH_EXP_DIG ||
           ph == PH_TRAIL;
  endfunction

  function automatic logic [3:0] step_phase(logic [3:0] ph, logic [7:0] c);
    if (ph >= PH_REJECT) return PH_REJECT;
    if (is_blank(c)) begin
      if (ph == PH_LEAD) return PH_LEAD;
      return phase_accepts(ph) ? PH_TRAIL : PH_REJECT;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (ph == PH_LEAD || ph == PH_SIGN || ph == PH_INT) return PH_INT;
      if (ph == PH_PT_NOINT || ph == PH_PT_INT || ph == PH_FRAC) return PH_FRAC;
      if (ph == PH_EXP || ph == PH_EXP_SIGN || ph == PH_EXP_DIG) return PH_EXP_DIG;
      return PH_REJECT;
    end
    if (c == CH_PLUS || c == CH_MINUS) begin
      if (ph == PH_LEAD) return PH_SIGN;
      return (ph == PH_EXP) ? PH_EXP_SIGN : PH_REJECT;
    end
    if (c == CH_POINT) begin
      if (ph == PH_LEAD || ph == PH_SIGN) return PH_PT_NOINT;
      return (ph == PH_INT) ? PH_PT_INT : PH_REJECT;
    end
    if (c == CH_LOW_E || c == CH_UP_E)
      return (ph == PH_INT || ph == PH_PT_INT || ph == PH_FRAC) ? PH_EXP : PH_REJECT;
    return PH_REJECT;
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // bytes that matter to the grammar, for noise and mutations
  function automatic logic [7:0] random_token_byte();
    case ($urandom_range(0, 6))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_POINT;
      3: return CH_LOW_E;
      4: return CH_UP_E;
      5: return random_blank();
      default: return random_digit();
    endcase
  endfunction

  task automatic push_word(logic [7:0] ch, logic present, logic last);
    text_word_t w;
    w.ch = ch;
    w.present = present;
    w.last = last;
    text_words.push_back(w);
    if (present || last) phase_words++;
  endtask

  task automatic push_str(string s, bit close);
    for (int i = 0; i < s.len(); i++)
      push_word(s[i], 1'b1, close && (i == s.len() - 1));
  endtask

  task automatic push_digits(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) text_buf.push_back(random_digit());
  endtask

  // well-formed literal with random content
  task automatic build_literal();
    text_buf.delete();
    repeat ($urandom_range(0, 2)) text_buf.push_back(random_blank());
    if ($urandom_range(0, 2) == 0) text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    case ($urandom_range(0, 2))
      0: push_digits(1, 4);
      1: begin
        push_digits(1, 3);
        text_buf.push_back(CH_POINT);
        push_digits(0, 3);
      end
      default: begin
        text_buf.push_back(CH_POINT);
        push_digits(1, 3);
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      text_buf.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
      if ($urandom_range(0, 1)) text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      push_digits(1, 3);
    end
    repeat ($urandom_range(0, 2)) text_buf.push_back(random_blank());
  endtask

  task automatic mangle_text();
    int pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case (mutation_t'($urandom_range(0, 4)))
      MUT_REPLACE:     text_buf[pos] = 8'($urandom_range(0, 255));
      MUT_INNER_SPACE: text_buf.insert(pos, random_blank());
      MUT_TAIL_JUNK: begin
        text_buf.push_back(random_blank());
        text_buf.push_back($urandom_range(0, 1) ? random_token_byte() : 8'($urandom));
      end
      MUT_DROP:        text_buf.delete(pos);
      default:         text_buf.insert(pos, random_token_byte());
    endcase
  endtask

  task automatic build_noise(bit blanks_only);
    int n;
    text_buf.delete();
    n = $urandom_range(1, 6);
    repeat (n) begin
      if (blanks_only) text_buf.push_back(random_blank());
      else text_buf.push_back($urandom_range(0, 1) ? random_token_byte() : 8'($urandom));
    end
  endtask

  // a text may also close on a no-character word; stray no-character words are ignored
  task automatic send_text();
    bit close_empty;
    close_empty = (text_buf.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (text_buf[i]) begin
      if ($urandom_range(0, 32) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(text_buf[i], 1'b1, !close_empty && (i == text_buf.size() - 1));
    end
    if (close_empty) push_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_all();
    while (text_words.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_verdicts.size() > 0) @(posedge clk);
  endtask

  // driver; also tracks the phase on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        words_sent++;
        if (s_tuser) recognizer_phase = step_phase(recognizer_phase, s_tdata);
        if (s_tlast) begin
          expected_verdicts.push_back(phase_accepts(recognizer_phase));
          recognizer_phase = PH_LEAD;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (text_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_word = text_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_word.ch;
          s_tuser  <= next_word.present;
          s_tlast  <= next_word.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("is_numeric: no verdict expected, actual %0b", m_tdata[0]);
          error_count++;
        end else begin
          want_verdict = expected_verdicts.pop_front();
          texts_checked++;
          if (want_verdict) numeric_seen++;
          if (m_tdata[0] !== want_verdict) begin
            $error("is_numeric: expected %0b, actual %0b", want_verdict, m_tdata[0]);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin
    int kind;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed texts, no idling
    push_word(CH_ZERO, 1'b0, 1'b1);               // empty text
    push_str("+0.e-9", 0);
    push_word(CH_CR, 1'b1, 1'b1);                 // trailing whitespace
    push_str("1E 2", 1);                          // blank inside the number
    push_word(CH_TAB, 1'b1, 1'b1);                // whitespace only
    push_word(CH_NINE, 1'b1, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);                 // zero byte
    push_word(8'hFF, 1'b1, 1'b1);
    push_str("-.", 1);
    push_word(CH_POINT, 1'b1, 1'b0);
    push_word(8'hA5, 1'b0, 1'b0);                 // ignored, not last
    push_str("7", 0);
    push_word(8'h5A, 1'b0, 1'b1);                 // closes on no-character word
    push_str("1 x", 1);                           // junk after trailing blank
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      phase_words = 0;
      while (phase_words < 390) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          build_literal();
        end else if (kind < 80) begin
          build_literal();
          mangle_text();
        end else if (kind < 92) begin
          build_noise(0);
        end else if (kind < 96) begin
          text_buf.delete();
        end else begin
          build_noise(1);
        end
        send_text();
      end
      // hold input until every verdict is back
      drain_all();
    end

    repeat (20) @(posedge clk);
    $display("%0d words sent, %0d texts checked (%0d numeric, %0d rejected)",
             words_sent, texts_checked, numeric_seen, texts_checked - numeric_seen);
    $display("idle mixes: none, sender 48%%, receiver 48%%, both 25%%");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
